FILE: hw/rtl/bbpt_pkg.sv
package bbpt_pkg;

  localparam int CoordW = 16;
  localparam int DivW   = 5;

  typedef struct packed {
    logic                     cmd;
    logic [1:0]               point_row;
    logic [1:0]               point_col;
    logic signed [CoordW-1:0] load_x;
    logic signed [CoordW-1:0] load_y;
    logic signed [CoordW-1:0] load_z;
    logic [DivW-1:0]          strip_index;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vert_x;
    logic signed [CoordW-1:0] vert_y;
    logic signed [CoordW-1:0] vert_z;
    logic                     strip_end;
  } out_word_t;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdStrip = 1'b1;

  // datapath commands
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_PARAM,   // start divide for k/D
    DP_WEIGHT,  // compute weights step
    DP_BLEND,   // one MAC step
    DP_FIN      // round/saturate accumulator
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       wsel;      // 0 row weights, 1 column weights
    logic [1:0] wstep;
    logic [1:0] j;         // blend term
    logic [1:0] r;         // row
    logic [1:0] c;         // coord
    logic       to_mid;    // FIN target: mid[r] vs result[c]
    logic [DivW-1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

  // default patch, quarter positions in 2^-2 units scaled later
  function automatic logic signed [3:0] quarter_pos(input logic [1:0] i);
    logic signed [3:0] q;
    unique case (i)
      2'd0: q = -4'sd3;
      2'd1: q = -4'sd1;
      2'd2: q = 4'sd1;
      default: q = 4'sd3;
    endcase
    return q;
  endfunction

  function automatic logic signed [3:0] dflt_z(input logic [3:0] i);
    logic signed [3:0] q;
    unique case (i)
      4'd0, 4'd3, 4'd12, 4'd15: q = -4'sd2;
      4'd4, 4'd7:               q = -4'sd3;
      4'd5, 4'd6:               q = 4'sd2;
      4'd9, 4'd10:              q = -4'sd2;
      4'd13, 4'd14:             q = -4'sd4;
      default:                  q = 4'sd0;
    endcase
    return q;
  endfunction

endpackage

FILE: hw/rtl/bbpt_datapath.sv
module bbpt_datapath #(
  parameter int CoordBits = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bbpt_pkg::dp_cmd_t           cmd,
  input  bbpt_pkg::in_word_t          in_word,
  input  logic [bbpt_pkg::DivW-1:0]   div_eff,
  output bbpt_pkg::dp_stat_t          stat,
  output logic signed [CoordBits-1:0] res [3]
);
  import bbpt_pkg::*;

  localparam int AccW = CoordBits + 20;

  logic signed [CoordBits-1:0] cpx [16];
  logic signed [CoordBits-1:0] cpy [16];
  logic signed [CoordBits-1:0] cpz [16];
  logic [15:0] written;

  // restoring divider for T = (k*65536 + D/2) / D, one quotient bit a cycle;
  // quo starts as the numerator and fills with quotient bits from the bottom
  logic [4:0]  rem;
  logic [21:0] quo;
  logic [4:0]  div_cnt;
  logic        div_busy;
  logic [21:0] num;
  logic [6:0]  sub;

  logic [16:0] t_val, s_val;
  logic [16:0] t2, s2;
  logic [16:0] wrow [4];
  logic [16:0] wcol [4];
  logic signed [CoordBits-1:0] mid [4];
  logic signed [AccW-1:0] acc;

  logic signed [CoordBits-1:0] pval;
  logic [16:0] wv;
  logic signed [AccW-1:0] prod;
  logic signed [AccW-1:0] rsum;
  logic signed [AccW-1:0] rdiv;
  logic signed [CoordBits-1:0] satv;
  logic [34:0] mul_a;
  logic [36:0] mul_r;
  logic [16:0] wres;
  logic [3:0]  cidx;
  logic signed [CoordBits-1:0] dflt;
  logic [36:0] w1p, w2p;

  localparam logic signed [AccW-1:0] Hi = AccW'((1 << (CoordBits - 1)) - 1);
  localparam logic signed [AccW-1:0] Lo = -Hi - AccW'(1);

  assign stat.div_busy = div_busy;
  assign cidx = {cmd.r, cmd.j};

  always_comb begin
    logic signed [CoordBits-1:0] pv;
    unique case (cmd.c)
      2'd0:    pv = cpx[cidx];
      2'd1:    pv = cpy[cidx];
      default: pv = cpz[cidx];
    endcase
    unique case (cmd.c)
      2'd0:    dflt = CoordBits'(quarter_pos(cmd.j)) <<< (CoordBits - 5);
      2'd1:    dflt = CoordBits'(quarter_pos(cmd.r)) <<< (CoordBits - 5);
      default: dflt = CoordBits'(dflt_z(cidx)) <<< (CoordBits - 5);
    endcase
    pval = written[cidx] ? pv : dflt;
  end

  always_comb begin
    if (cmd.wsel) begin
      wv = wcol[cmd.j];
      prod = AccW'($signed({1'b0, wv})) * AccW'(mid[cmd.j]);
    end else begin
      wv = wrow[cmd.j];
      prod = AccW'($signed({1'b0, wv})) * AccW'(pval);
    end
    rsum = acc + AccW'(32768);
    rdiv = rsum >>> 16;
    if (rdiv > Hi) satv = Hi[CoordBits-1:0];
    else if (rdiv < Lo) satv = Lo[CoordBits-1:0];
    else satv = rdiv[CoordBits-1:0];
  end

  // weight steps share one multiplier (mul_a); step 2 also uses w1p and w2p
  always_comb begin
    unique case (cmd.wstep)
      2'd0: mul_a = 35'(t_val) * 35'(t_val);
      2'd1: mul_a = 35'(s_val) * 35'(s_val);
      2'd2: mul_a = 35'(t2) * 35'(t_val);
      default: mul_a = 35'(s2) * 35'(s_val);
    endcase
    mul_r = 37'(mul_a) + 37'd32768;
    wres = mul_r[32:16];
  end

  assign t_val = quo[16:0];
  assign s_val = 17'h10000 - t_val;
  assign num = 22'({cmd.k, 16'd0}) + 22'(div_eff >> 1);
  assign sub = {1'b0, rem, quo[21]} - {2'b00, div_eff};

  assign w1p = 37'(t2) * 37'(s_val) * 37'd3 + 37'd32768;
  assign w2p = 37'(s2) * 37'(t_val) * 37'd3 + 37'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else begin
      if (cmd.op == DP_LOAD) begin
        written[{in_word.point_row, in_word.point_col}] <= 1'b1;
      end
      if (cmd.op == DP_PARAM) begin
        div_busy <= 1'b1;
        div_cnt  <= 5'd22;
      end else if (div_busy) begin
        div_cnt <= div_cnt - 5'd1;
        if (div_cnt == 5'd1) div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        cpx[{in_word.point_row, in_word.point_col}] <= in_word.load_x;
        cpy[{in_word.point_row, in_word.point_col}] <= in_word.load_y;
        cpz[{in_word.point_row, in_word.point_col}] <= in_word.load_z;
      end
      DP_PARAM: begin
        rem <= '0;
        quo <= num;
      end
      DP_WEIGHT: begin
        unique case (cmd.wstep)
          2'd0: begin t2 <= wres; s2 <= s2; end
          2'd1: s2 <= wres;
          2'd2: begin
            if (cmd.wsel) begin
              wcol[0] <= wres;
              wcol[1] <= w1p[32:16];
              wcol[2] <= w2p[32:16];
            end else begin
              wrow[0] <= wres;
              wrow[1] <= w1p[32:16];
              wrow[2] <= w2p[32:16];
            end
          end
          default: begin
            if (cmd.wsel) wcol[3] <= wres;
            else wrow[3] <= wres;
          end
        endcase
      end
      DP_BLEND: begin
        acc <= (cmd.j == 2'd0) ? prod : acc + prod;
      end
      DP_FIN: begin
        if (cmd.to_mid) mid[cmd.r] <= satv;
        else res[cmd.c] <= satv;
      end
      default: begin
      end
    endcase
    // divider iteration: shift in the next numerator bit, keep it if it fits
    if (div_busy) begin
      if (!sub[6]) begin
        rem <= sub[4:0];
        quo <= {quo[20:0], 1'b1};
      end else begin
        rem <= {rem[3:0], quo[21]};
        quo <= {quo[20:0], 1'b0};
      end
    end
  end

  logic unused;
  assign unused = ^{quo[21:17], sub[5], in_word.cmd, in_word.strip_index};

endmodule

FILE: hw/rtl/bbpt_ctrl.sv
module bbpt_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bbpt_pkg::in_word_t        in_word,
  input  logic [bbpt_pkg::DivW-1:0] div_eff,
  input  bbpt_pkg::dp_stat_t        stat,
  output bbpt_pkg::dp_cmd_t         cmd,
  output logic                      out_load,
  output logic                      out_last,
  input  logic                      out_free
);
  import bbpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_WGT, S_MAC, S_FIN, S_EMIT
  } state_t;

  state_t state;
  logic [DivW-1:0] s_idx, v;
  logic half, wsel;
  logic [1:0] wstep, j, r, c;
  logic row_phase;   // 1 while blending rows into mid

  logic [DivW-1:0] kcur;
  assign kcur = wsel ? v : (half ? s_idx : s_idx - DivW'(1));

  logic strip_ok;
  assign strip_ok = in_word.strip_index != '0 && in_word.strip_index <= div_eff;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.wsel = wsel;
    cmd.wstep = wstep;
    cmd.j = j;
    cmd.r = r;
    cmd.c = c;
    cmd.to_mid = row_phase;
    cmd.k = kcur;
    cmd.op = DP_NOP;
    unique case (state)
      S_IDLE: if (in_valid && in_word.cmd == CmdLoad) cmd.op = DP_LOAD;
      S_DIV:  if (!stat.div_busy && wstep == 2'd0 && j == 2'd0) cmd.op = DP_PARAM;
      S_WGT:  cmd.op = DP_WEIGHT;
      S_MAC:  begin
        cmd.op = DP_BLEND;
        cmd.wsel = !row_phase;
      end
      S_FIN:  cmd.op = DP_FIN;
      default: cmd.op = DP_NOP;
    endcase
  end

  assign out_load = state == S_EMIT && out_free;
  assign out_last = v == div_eff && half;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      s_idx <= '0; v <= '0; half <= 1'b0; wsel <= 1'b0;
      wstep <= '0; j <= '0; r <= '0; c <= '0; row_phase <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid && in_word.cmd == CmdStrip && strip_ok) begin
          s_idx <= in_word.strip_index;
          v <= '0; half <= 1'b0; wsel <= 1'b0;
          wstep <= '0; j <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // j used as "divide launched" flag
          if (j == 2'd0) j <= 2'd1;
          else if (!stat.div_busy) begin
            j <= '0; wstep <= '0; state <= S_WGT;
          end
        end
        S_WGT: begin
          wstep <= wstep + 2'd1;
          if (wstep == 2'd3) begin
            if (!wsel) begin
              wsel <= 1'b1; state <= S_DIV;
            end else begin
              wsel <= 1'b0; c <= '0; r <= '0; j <= '0;
              row_phase <= 1'b1; state <= S_MAC;
            end
          end
        end
        S_MAC: begin
          j <= j + 2'd1;
          if (j == 2'd3) state <= S_FIN;
        end
        S_FIN: begin
          state <= S_MAC;
          if (row_phase) begin
            r <= r + 2'd1;
            if (r == 2'd3) row_phase <= 1'b0;
          end else begin
            row_phase <= 1'b1;
            r <= '0;
            c <= c + 2'd1;
            if (c == 2'd2) state <= S_EMIT;
          end
        end
        S_EMIT: if (out_free) begin
          if (half) begin
            half <= 1'b0;
            if (v == div_eff) state <= S_IDLE;
            else begin v <= v + DivW'(1); state <= S_DIV; end
          end else begin
            half <= 1'b1; state <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("accept while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> state == S_EMIT) else $error("load outside emit");
  a_v_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> v <= div_eff) else $error("column past end");
`endif

endmodule

FILE: hw/rtl/bicubic_bezier_patch_tessellator_top.sv
// Each vertex of a strip takes two 22-step divides with 4 weight steps each,
// then 15 four-term MAC passes, and is then loaded into the output register.
// A strip of D divisions holds the input until its last vertex is loaded;
// loads and strips outside 1..D are taken without holding it. Output stalls
// hold the controller in its emit state behind the single output register.
// Synchronous active-high reset restores the default patch and divisions=7.
module bicubic_bezier_patch_tessellator_top #(
  parameter int MAX_DIVISIONS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bbpt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bbpt_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);
  import bbpt_pkg::*;

  logic [DivW-1:0] divisions, div_eff;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic signed [CoordW-1:0] res [3];
  logic out_load, out_last, out_free;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (divisions == '0) div_eff = DivW'(1);
    else if (32'(divisions) > MAX_DIVISIONS) div_eff = DivW'(MAX_DIVISIONS);
    else div_eff = divisions;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisions <= DivW'(7);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) divisions <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data.vert_x    <= res[0];
      out_data.vert_y    <= res[1];
      out_data.vert_z    <= res[2];
      out_data.strip_end <= out_last;
    end
  end

  bbpt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_word(in_data), .div_eff,
    .stat, .cmd, .out_load, .out_last, .out_free
  );

  bbpt_datapath #(.CoordBits(CoordW)) u_dp (
    .clk, .rst, .cmd, .in_word(in_data), .div_eff, .stat, .res
  );

endmodule
